### rtl/smvm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply package
// Shared sizes, field widths, command word and state types for the
// coordinate-list sparse matrix-vector multiply block.
// ----------------------------------------------------------------------------
package smvm_pkg;

    // Matrix size limits, fixed for this build
    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int COL_AW   = $clog2(MAX_COLS);

    // Field widths
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 48;
    localparam int PROD_W = 2 * VAL_W;
    localparam int FRAC_W = 16;

    // Stream port widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // Configuration port
    localparam int CFG_W  = 11;
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 11'd1024;

    // Function codes on the input word
    localparam logic [S_TUSER_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [S_TUSER_W-1:0] FUNC_NONZERO = 2'd1;
    localparam logic [S_TUSER_W-1:0] FUNC_READ    = 2'd2;

    // Status codes on the result word
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Clearing sweep over both stores after reset
    localparam int CLR_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);

    // Command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Operation decided by the front end
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_READ,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [ROW_AW-1:0]         row;
        logic [COL_AW-1:0]         col;
        logic signed [VAL_W-1:0]   value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } back_state_t;

endpackage

### rtl/sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply
// Computes y = A*x from a stream of vector loads, coordinate-list nonzero
// entries and row reads, in Q16.16 with saturating Q32.16 row sums.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ stream. s_tuser selects the function: load a
//   vector element, multiply-accumulate a nonzero entry into its row, or read
//   and clear one row sum. Every word gives exactly one result word on the m_
//   stream, in order: m_tuser is the status (set when an index is outside
//   the configured size or the function is unused), m_tdata the row sum on a
//   read and zero otherwise. num_rows and num_cols are written on the cfg_
//   port while the block is idle.
//   Each word passes through the execution unit in store read, multiply, and
//   accumulate and write-back, and the accumulator read-modify-write
//   completes before the next word reads the stores; the result word is
//   registered in the output register, and the write-back waits while an
//   earlier result is stalled there. After reset both stores are cleared
//   in a sweep over all 1024 entries, during which s_tready is low;
//   configuration writes are taken throughout.
//   When the receiver stalls, the result waits in the output register and a
//   four-entry command queue keeps accepting words until it fills.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration
    input  logic                               cfg_wr_en,
    input  logic [smvm_pkg::CFG_AW-1:0]        cfg_index,
    input  logic [smvm_pkg::CFG_W-1:0]         cfg_wr_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // row_index[9:0], col_index[19:10], item_value[51:20], zero[55:52]
    input  logic [smvm_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [smvm_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // row_sum[47:0]
    output logic [smvm_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[0]
    output logic [smvm_pkg::M_TUSER_W-1:0]     m_tuser
);
    import smvm_pkg::*;

    logic clearing;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_en;
    cmd_t pop_cmd;

    smvm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .clearing    (clearing),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    smvm_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_en     (pop_en),
        .pop_cmd    (pop_cmd)
    );

    smvm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_en    (pop_en),
        .pop_cmd   (pop_cmd),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/smvm_front.sv
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply front end
// Holds the size registers, accepts input words, checks indexes against the
// configured size and pushes one command per word into the queue.
// ----------------------------------------------------------------------------
module smvm_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [smvm_pkg::CFG_AW-1:0]        cfg_index,
    input  logic [smvm_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [smvm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [smvm_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                               clearing,
    output logic                               push_valid,
    input  logic                               push_ready,
    output smvm_pkg::cmd_t                     push_cmd
);
    import smvm_pkg::*;

    logic [CFG_W-1:0]        num_rows_reg;
    logic [CFG_W-1:0]        num_cols_reg;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] item_value;
    logic                    row_ok;
    logic                    col_ok;
    op_t                     op;

    // Write size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= CFG_SIZE_RESET;
            num_cols_reg <= CFG_SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NUM_ROWS: num_rows_reg <= cfg_wr_data;
                CFG_NUM_COLS: num_cols_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Unpack the word
    assign row_index  = s_tdata[IDX_W-1:0];
    assign col_index  = s_tdata[2*IDX_W-1:IDX_W];
    assign item_value = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    // Range checks against configured and built size
    assign row_ok = ({1'b0, row_index} < num_rows_reg) && (32'(row_index) < MAX_ROWS);
    assign col_ok = ({1'b0, col_index} < num_cols_reg) && (32'(col_index) < MAX_COLS);

    // Classify the word
    always_comb begin
        case (s_tuser)
            FUNC_LOAD:    op = col_ok ? OP_LOAD : OP_REJECT;
            FUNC_NONZERO: op = (row_ok && col_ok) ? OP_MAC : OP_REJECT;
            FUNC_READ:    op = row_ok ? OP_READ : OP_REJECT;
            default:      op = OP_REJECT;
        endcase
    end

    // Accept only while the queue has room and the stores are not clearing
    assign s_tready   = push_ready && !clearing;
    assign push_valid = s_tvalid && s_tready;

    assign push_cmd.op    = op;
    assign push_cmd.row   = row_index[ROW_AW-1:0];
    assign push_cmd.col   = col_index[COL_AW-1:0];
    assign push_cmd.value = item_value;

endmodule

### rtl/smvm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply command queue
// Short queue of classified commands between the front end and the
// execution back end.
// ----------------------------------------------------------------------------
module smvm_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  smvm_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_en,
    output smvm_pkg::cmd_t  pop_cmd
);
    import smvm_pkg::*;

    cmd_t               slots [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_en && pop_valid;
    assign pop_cmd    = slots[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/smvm_back.sv
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply back end
// Holds the vector store and the row accumulators, clears both after reset,
// runs one command at a time through read, multiply and write-back, and
// keeps the result word in an output register.
// ----------------------------------------------------------------------------
module smvm_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               pop_valid,
    output logic                               pop_en,
    input  smvm_pkg::cmd_t                     pop_cmd,
    output logic                               clearing,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [smvm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [smvm_pkg::M_TUSER_W-1:0]     m_tuser
);
    import smvm_pkg::*;

    // Stores
    logic signed [VAL_W-1:0] vec_mem [MAX_COLS];
    logic signed [SUM_W-1:0] acc_mem [MAX_ROWS];

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [CLR_AW-1:0]       clr_cnt_reg;
    logic [CLR_AW-1:0]       clr_cnt_next;
    cmd_t                    cmd_reg;
    logic signed [VAL_W-1:0] vec_rd_reg;
    logic signed [SUM_W-1:0] acc_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] prod_q;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    out_valid_reg;
    logic                    out_status_reg;
    logic [SUM_W-1:0]        out_sum_reg;

    logic                    out_fire;
    logic                    out_load;
    logic                    out_status;
    logic [SUM_W-1:0]        out_sum;
    logic                    vec_we;
    logic [COL_AW-1:0]       vec_waddr;
    logic signed [VAL_W-1:0] vec_wdata;
    logic                    acc_we;
    logic [ROW_AW-1:0]       acc_waddr;
    logic signed [SUM_W-1:0] acc_wdata;

    // Truncate the Q32.32 product to Q32.16 (floor) and add with saturation
    assign prod_q   = prod_reg[PROD_W-1:FRAC_W];
    assign sum_wide = {acc_rd_reg[SUM_W-1], acc_rd_reg} + {prod_q[SUM_W-1], prod_q};
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    assign out_fire = !out_valid_reg || m_tready;
    assign clearing = (state_reg == ST_CLEAR);

    // Next state, store writes and result load
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pop_en       = 1'b0;
        out_load     = 1'b0;
        out_status   = STATUS_OK;
        out_sum      = '0;
        vec_we       = 1'b0;
        vec_waddr    = cmd_reg.col;
        vec_wdata    = cmd_reg.value;
        acc_we       = 1'b0;
        acc_waddr    = cmd_reg.row;
        acc_wdata    = '0;
        case (state_reg)
            ST_CLEAR: begin
                vec_we       = (32'(clr_cnt_reg) < MAX_COLS);
                vec_waddr    = clr_cnt_reg[COL_AW-1:0];
                vec_wdata    = '0;
                acc_we       = (32'(clr_cnt_reg) < MAX_ROWS);
                acc_waddr    = clr_cnt_reg[ROW_AW-1:0];
                acc_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop_valid) begin
                    pop_en     = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_fire) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (cmd_reg.op)
                        OP_LOAD: begin
                            vec_we = 1'b1;
                        end
                        OP_MAC: begin
                            acc_we    = 1'b1;
                            acc_wdata = sum_sat;
                        end
                        OP_READ: begin
                            acc_we    = 1'b1;
                            acc_wdata = '0;
                            out_sum   = acc_rd_reg;
                        end
                        default: begin
                            out_status = STATUS_ERROR;
                        end
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Vector store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (vec_we) begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        if (pop_en) begin
            vec_rd_reg <= vec_mem[pop_cmd.col];
        end
    end

    // Row accumulators: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (pop_en) begin
            acc_rd_reg <= acc_mem[pop_cmd.row];
        end
    end

    // Hold the command and register the product
    always_ff @(posedge aclk) begin
        if (pop_en) begin
            cmd_reg <= pop_cmd;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= cmd_reg.value * vec_rd_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status;
            out_sum_reg    <= out_sum;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_status_reg;

endmodule

### rtl/smvm_checker.sv
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply checker
// Port-level checks on reset behavior, the clearing sweep and result words.
// ----------------------------------------------------------------------------
module smvm_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [smvm_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [smvm_pkg::M_TUSER_W-1:0]     m_tuser
);
    import smvm_pkg::*;

    // Reset drops any pending result
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Stores are being cleared right after reset: no word is taken
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted during clearing sweep");

    // An error result carries a zero sum
    a_error_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] == STATUS_ERROR)) |-> (m_tdata == '0))
        else $error("error result with nonzero sum");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind sparse_matrix_vector_multiply smvm_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/sparse_matrix_vector_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply testbench
// Drives vector loads, nonzero entries, row reads and unused codes through
// the input stream under random sender gaps and receiver stalls. A local
// Q16.16 / Q32.16 model of the vector store and the row sums predicts every
// result word, and each word is checked in order. The size registers are
// written between phases: reset sizes, the smallest, zero, the largest
// writable value, and writes to unused register indexes.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_test;
    import smvm_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_GAP        = 17;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PAD_W          = S_TDATA_W - VAL_W - 2 * IDX_W;

    localparam logic [S_TUSER_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [CFG_AW-1:0]    CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_AW-1:0]    CFG_SPARE_HI = 2'd3;

    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic                    status;
        logic [SUM_W-1:0]        row_sum;
    } spmv_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_AW-1:0]           cfg_index;
    logic [CFG_W-1:0]            cfg_wr_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [S_TDATA_W-1:0]        s_tdata;
    logic [S_TUSER_W-1:0]        s_tuser;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [M_TDATA_W-1:0]        m_tdata;
    logic [M_TUSER_W-1:0]        m_tuser;

    // Local copy of the block's state
    logic signed [VAL_W-1:0]     x_vector [MAX_COLS];
    logic signed [SUM_W-1:0]     row_sums [MAX_ROWS];
    logic [CFG_W-1:0]            rows_cfg;
    logic [CFG_W-1:0]            cols_cfg;

    spmv_result_t                awaited_results [$];

    bit                          tx_quiet;
    bit                          rx_quiet;
    int unsigned                 mismatches;
    int unsigned                 words_sent;
    int unsigned                 results_checked;
    int unsigned                 error_statuses;
    int unsigned                 saturations;
    int unsigned                 func_counts [4];
    int unsigned                 size_settings;

    sparse_matrix_vector_multiply u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Apply one word to the model and return the result it should give
    function automatic spmv_result_t spmv_execute(logic [S_TUSER_W-1:0] func,
                                                  logic [IDX_W-1:0] row,
                                                  logic [IDX_W-1:0] col,
                                                  logic signed [VAL_W-1:0] value);
        spmv_result_t res;
        longint       prod;
        longint       acc;
        res.status  = STATUS_ERROR;
        res.row_sum = '0;
        case (func)
            FUNC_LOAD: begin
                if (col < cols_cfg) begin
                    x_vector[col] = value;
                    res.status    = STATUS_OK;
                end
            end
            FUNC_NONZERO: begin
                if (row < rows_cfg && col < cols_cfg) begin
                    // floor of the Q32.32 product down to Q32.16
                    prod = (longint'(value) * longint'(x_vector[col])) >>> FRAC_W;
                    acc  = longint'(row_sums[row]) + prod;
                    if (acc > SUM_MAX) begin
                        acc = SUM_MAX;
                        saturations++;
                    end else if (acc < SUM_MIN) begin
                        acc = SUM_MIN;
                        saturations++;
                    end
                    row_sums[row] = acc[SUM_W-1:0];
                    res.status    = STATUS_OK;
                end
            end
            FUNC_READ: begin
                if (row < rows_cfg) begin
                    res.row_sum   = row_sums[row];
                    row_sums[row] = '0;
                    res.status    = STATUS_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Send one word, then predict its result once it is accepted
    task automatic send_word(logic [S_TUSER_W-1:0] func, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
        int unsigned  gap;
        spmv_result_t res;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge aclk) s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{PAD_W{1'b0}}, value, col, row};
        do @(posedge aclk); while (!s_tready);
        res = spmv_execute(func, row, col, value);
        awaited_results.insert(awaited_results.size(), res);
        words_sent++;
        func_counts[func]++;
        if (res.status == STATUS_ERROR)
            error_statuses++;
    endtask

    // Hold off the sender until every result is back and the block is quiet
    task automatic wait_for_results();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; only called while the block is idle
    task automatic write_reg(logic [CFG_AW-1:0] index, logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        if (index == CFG_NUM_ROWS)
            rows_cfg = data;
        else if (index == CFG_NUM_COLS)
            cols_cfg = data;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic set_size(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        write_reg(CFG_NUM_ROWS, rows);
        write_reg(CFG_NUM_COLS, cols);
        size_settings++;
    endtask

    function automatic logic signed [VAL_W-1:0] draw_value();
        logic signed [VAL_W-1:0] v;
        int unsigned             pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = $urandom;
        else if (pick < 8)
            v = $urandom_range(0, 1 << 20) - (1 << 19);
        else begin
            case ($urandom_range(0, 3))
                0:       v = VAL_MAX;
                1:       v = VAL_MIN;
                2:       v = '0;
                default: v = '1;
            endcase
        end
        return v;
    endfunction

    // Index inside the configured size, or any index when the size is zero
    function automatic logic [IDX_W-1:0] draw_index(logic [CFG_W-1:0] size);
        int unsigned lim;
        lim = (32'(size) > MAX_ROWS) ? MAX_ROWS : 32'(size);
        if (lim == 0)
            return IDX_W'($urandom_range(0, MAX_ROWS - 1));
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // Extreme values, edge indexes, saturation both ways, rounding, unused code
    task automatic test_directed_ops();
        send_word(FUNC_LOAD, 10'd0, 10'd0, VAL_MAX);
        send_word(FUNC_LOAD, 10'd1023, 10'd1023, VAL_MIN);
        send_word(FUNC_LOAD, 10'd0, 10'd512, VAL_ONE);
        send_word(FUNC_LOAD, 10'd0, 10'd341, '1);
        repeat (3) send_word(FUNC_NONZERO, 10'd0, 10'd0, VAL_MAX);
        repeat (3) send_word(FUNC_NONZERO, 10'd1023, 10'd1023, VAL_MAX);
        send_word(FUNC_NONZERO, 10'd682, 10'd512, '0);
        send_word(FUNC_NONZERO, 10'd682, 10'd341, VAL_MIN);
        // tiny negative product floors to minus one LSB
        send_word(FUNC_NONZERO, 10'd682, 10'd341, 32'sd1);
        send_word(FUNC_READ, 10'd0, 10'd0, '0);
        send_word(FUNC_READ, 10'd1023, 10'd0, '0);
        send_word(FUNC_READ, 10'd682, 10'd0, '0);
        send_word(FUNC_READ, 10'd0, 10'd0, '0);
        send_word(FUNC_UNUSED, 10'd1, 10'd1, VAL_ONE);
        wait_for_results();
    endtask

    // Smallest, zero, largest sizes and writes to unused register indexes
    task automatic test_size_limits();
        set_size(11'd1, 11'd1);
        send_word(FUNC_LOAD, 10'd0, 10'd1, VAL_ONE);
        send_word(FUNC_LOAD, 10'd0, 10'd0, VAL_ONE);
        send_word(FUNC_NONZERO, 10'd1, 10'd0, VAL_ONE);
        send_word(FUNC_NONZERO, 10'd0, 10'd1, VAL_ONE);
        send_word(FUNC_NONZERO, 10'd0, 10'd0, VAL_ONE);
        send_word(FUNC_READ, 10'd1, 10'd0, '0);
        send_word(FUNC_READ, 10'd0, 10'd0, '0);
        wait_for_results();
        set_size(11'd0, 11'd0);
        send_word(FUNC_LOAD, 10'd0, 10'd0, VAL_ONE);
        send_word(FUNC_READ, 10'd0, 10'd0, '0);
        wait_for_results();
        write_reg(CFG_SPARE_LO, 11'h7FF);
        write_reg(CFG_SPARE_HI, 11'h7FF);
        send_word(FUNC_NONZERO, 10'd0, 10'd0, VAL_ONE);
        wait_for_results();
        set_size(11'h7FF, 11'h7FF);
        send_word(FUNC_READ, 10'd1023, 10'd0, '0);
        wait_for_results();
    endtask

    // Mostly well-formed load / accumulate / read runs, some noise words
    task automatic test_random_traffic(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                                       int unsigned count, bit quiet_tx, bit quiet_rx);
        int unsigned          start;
        int unsigned          n;
        bit                   paused;
        logic [IDX_W-1:0]     base;
        logic [IDX_W-1:0]     row;
        wait_for_results();
        set_size(rows, cols);
        tx_quiet = quiet_tx;
        rx_quiet = quiet_rx;
        start    = words_sent;
        paused   = 1'b0;
        while (words_sent - start < count) begin
            if ($urandom_range(0, 99) < 85) begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(FUNC_LOAD, IDX_W'($urandom), draw_index(cols),
                                     draw_value());
                // keep rows in a narrow window so sums build up
                base = draw_index(rows);
                n    = $urandom_range(1, 8);
                repeat (n) begin
                    row = base + IDX_W'($urandom_range(0, 3));
                    send_word(FUNC_NONZERO, row, draw_index(cols), draw_value());
                end
                n = $urandom_range(1, 3);
                repeat (n) begin
                    row = base + IDX_W'($urandom_range(0, 3));
                    send_word(FUNC_READ, row, IDX_W'($urandom), $urandom);
                end
            end else begin
                send_word(S_TUSER_W'($urandom_range(0, 3)), IDX_W'($urandom),
                          IDX_W'($urandom), draw_value());
            end
            // let the pipe empty once mid-phase
            if (!paused && words_sent - start >= count / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_for_results();
    endtask

    // Receiver with random stalls
    initial begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall) begin
                @(negedge aclk) m_tready <= 1'b0;
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge aclk) begin
        spmv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                $error("result word with no prediction pending: status %0d row_sum %h",
                       m_tuser[0], m_tdata);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser[0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser[0]);
                    mismatches++;
                end
                if (m_tdata !== want.row_sum) begin
                    $error("row_sum: expected %h, actual %h", want.row_sum, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Stop when no word moves on either side for too long
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Test sequence
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        rows_cfg    = CFG_SIZE_RESET;
        cols_cfg    = CFG_SIZE_RESET;
        for (int k = 0; k < MAX_COLS; k++)
            x_vector[k] = '0;
        for (int k = 0; k < MAX_ROWS; k++)
            row_sums[k] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_directed_ops();
        test_size_limits();
        test_random_traffic(11'd1024, 11'd1024, 100, 1'b0, 1'b0);
        test_random_traffic(11'd16, 11'd8, 110, 1'b0, 1'b0);
        test_random_traffic(11'd1, 11'd1, 60, 1'b1, 1'b0);
        test_random_traffic(11'd1024, 11'd1024, 120, 1'b1, 1'b1);
        test_random_traffic(11'd300, 11'h7FF, 120, 1'b0, 1'b1);
        wait_for_results();

        $display("covered %0d words: %0d loads, %0d nonzeros, %0d reads, %0d unused codes",
                 words_sent, func_counts[0], func_counts[1], func_counts[2], func_counts[3]);
        $display("%0d results checked, %0d error statuses, %0d saturated sums, %0d sizes",
                 results_checked, error_statuses, saturations, size_settings);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
